>>> rtl/cuckoo_filter_bucket_table_unit_macros.svh
// Assertion macros used by the cuckoo filter bucket table controller.
`ifndef CUCKOO_FILTER_BUCKET_TABLE_UNIT_MACROS_SVH
`define CUCKOO_FILTER_BUCKET_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, switched off while reset is high.
`define CFBT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define CFBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CFBT_ASSERT(lbl, clk, rst, prop, msg)
`define CFBT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/cfbt_pkg.sv
// Types, constants and slot helpers for the cuckoo filter bucket table.
`timescale 1ns / 1ps
package cfbt_pkg;

  localparam int BUCKET_COUNT     = 1024;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int BIDX_W           = $clog2(BUCKET_COUNT);
  localparam int SLOT_IDX_W       = $clog2(SLOTS_PER_BUCKET);
  localparam int TAG_W            = 32;
  localparam int BUCKET_W         = TAG_W * SLOTS_PER_BUCKET;
  localparam int SEL_W            = 3;
  localparam int CMD_W            = 3;
  localparam int COUNT_W          = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP2 = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP1 = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT   = 3'd4;

  // Tag width selector codes; anything above WSEL_32 reads as 32 bits
  localparam logic [SEL_W-1:0] WSEL_2  = 3'd0;
  localparam logic [SEL_W-1:0] WSEL_4  = 3'd1;
  localparam logic [SEL_W-1:0] WSEL_8  = 3'd2;
  localparam logic [SEL_W-1:0] WSEL_12 = 3'd3;
  localparam logic [SEL_W-1:0] WSEL_16 = 3'd4;
  localparam logic [SEL_W-1:0] WSEL_32 = 3'd5;
  localparam logic [SEL_W-1:0] WSEL_RESET = WSEL_8;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [BIDX_W-1:0]     bucket_index;
    logic [BIDX_W-1:0]     alt_bucket_index;
    logic [TAG_W-1:0]      tag_value;
    logic                  evict_on_full;
    logic [SLOT_IDX_W-1:0] victim_slot;
  } req_t;

  typedef struct packed {
    logic               success;
    logic               evicted;
    logic [TAG_W-1:0]   evicted_tag;
    logic [COUNT_W-1:0] occupied_count;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_we;
    logic rd_en;
    logic rd_alt;
    logic wb_en;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             clr_last;
    logic             hit;
    logic             any_empty;
    logic             evict_on_full;
    logic [CMD_W-1:0] command;
  } ctrl_status_t;

  // Mask for the selected tag width
  function automatic logic [TAG_W-1:0] tag_mask(logic [SEL_W-1:0] sel);
    logic [TAG_W-1:0] m;
    m = '1;
    unique case (sel)
      WSEL_2:  m = 32'h0000_0003;
      WSEL_4:  m = 32'h0000_000F;
      WSEL_8:  m = 32'h0000_00FF;
      WSEL_12: m = 32'h0000_0FFF;
      WSEL_16: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Read slot s of a packed bucket at the selected width
  function automatic logic [TAG_W-1:0] get_slot(logic [BUCKET_W-1:0] b,
                                                logic [SLOT_IDX_W-1:0] s,
                                                logic [SEL_W-1:0] sel);
    logic [TAG_W-1:0] v;
    v = '0;
    unique case (sel)
      WSEL_2:  v = 32'(b[{s, 1'b0} +: 2]);
      WSEL_4:  v = 32'(b[{s, 2'b0} +: 4]);
      WSEL_8:  v = 32'(b[{s, 3'b0} +: 8]);
      WSEL_12: v = 32'(b[7'(s) * 7'd12 +: 12]);
      WSEL_16: v = 32'(b[{s, 4'b0} +: 16]);
      default: v = b[{s, 5'b0} +: 32];
    endcase
    return v;
  endfunction

  // Overwrite slot s of a packed bucket with a tag at the selected width
  function automatic logic [BUCKET_W-1:0] put_slot(logic [BUCKET_W-1:0] b,
                                                  logic [SLOT_IDX_W-1:0] s,
                                                  logic [SEL_W-1:0] sel,
                                                  logic [TAG_W-1:0] tag);
    logic [BUCKET_W-1:0] r;
    r = b;
    unique case (sel)
      WSEL_2:  r[{s, 1'b0} +: 2]          = tag[1:0];
      WSEL_4:  r[{s, 2'b0} +: 4]          = tag[3:0];
      WSEL_8:  r[{s, 3'b0} +: 8]          = tag[7:0];
      WSEL_12: r[7'(s) * 7'd12 +: 12]     = tag[11:0];
      WSEL_16: r[{s, 4'b0} +: 16]         = tag[15:0];
      default: r[{s, 5'b0} +: 32]         = tag;
    endcase
    return r;
  endfunction

  // Lowest set bit of a slot vector
  function automatic logic [SLOT_IDX_W-1:0] first_set(
      logic [SLOTS_PER_BUCKET-1:0] v);
    logic [SLOT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

>>> rtl/cfbt_datapath.sv
// Datapath: bucket memory, item register, slot compares and result register.
`timescale 1ns / 1ps
module cfbt_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  cfbt_pkg::ctrl_cmd_t          cmd,
  output cfbt_pkg::ctrl_status_t       status,
  input  cfbt_pkg::req_t               req,
  input  logic                         cfg_we,
  input  logic [cfbt_pkg::SEL_W-1:0]   cfg_data,
  output cfbt_pkg::rsp_t               rsp
);

  logic [cfbt_pkg::BUCKET_W-1:0] mem [cfbt_pkg::BUCKET_COUNT];

  cfbt_pkg::req_t                  item;
  logic [cfbt_pkg::SEL_W-1:0]      tag_width_sel;
  logic [cfbt_pkg::BIDX_W-1:0]     clr_addr;
  logic [cfbt_pkg::BUCKET_W-1:0]   rd_data;

  logic [cfbt_pkg::BIDX_W-1:0]     rd_addr;
  logic [cfbt_pkg::BIDX_W-1:0]     wr_addr;
  logic [cfbt_pkg::BUCKET_W-1:0]   wr_data;
  logic [cfbt_pkg::BUCKET_W-1:0]   wb_data;
  logic                            wr_en;
  logic [cfbt_pkg::TAG_W-1:0]      tag_m;
  logic [cfbt_pkg::SLOTS_PER_BUCKET-1:0] match;
  logic [cfbt_pkg::SLOTS_PER_BUCKET-1:0] empty;
  logic                            hit;
  logic                            any_empty;
  logic                            do_evict;
  cfbt_pkg::rsp_t                  result;

  // Width register, written over the configuration channel
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_width_sel <= cfbt_pkg::WSEL_RESET;
    end else if (cfg_we) begin
      tag_width_sel <= cfg_data;
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_we) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Item held for the duration of its transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= req;
    end
  end

  // Memory ports: one write, one registered read
  assign rd_addr = cmd.rd_alt ? item.alt_bucket_index : req.bucket_index;
  assign wr_en   = cmd.clr_we | cmd.wb_en;
  assign wr_addr = cmd.clr_we ? clr_addr : item.bucket_index;
  assign wr_data = cmd.clr_we ? '0 : wb_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Four slot compares side by side
  assign tag_m = item.tag_value & cfbt_pkg::tag_mask(tag_width_sel);

  always_comb begin
    for (int s = 0; s < cfbt_pkg::SLOTS_PER_BUCKET; s++) begin
      match[s] = cfbt_pkg::get_slot(rd_data, cfbt_pkg::SLOT_IDX_W'(s), tag_width_sel) == tag_m;
      empty[s] = cfbt_pkg::get_slot(rd_data, cfbt_pkg::SLOT_IDX_W'(s), tag_width_sel) == '0;
    end
  end

  assign hit       = |match;
  assign any_empty = |empty;
  assign do_evict  = (item.command == cfbt_pkg::CMD_INSERT) && !any_empty && item.evict_on_full;

  // Bucket image written back on delete or insert
  always_comb begin
    if (item.command == cfbt_pkg::CMD_DELETE) begin
      wb_data = cfbt_pkg::put_slot(rd_data, cfbt_pkg::first_set(match), tag_width_sel, '0);
    end else if (any_empty) begin
      wb_data = cfbt_pkg::put_slot(rd_data, cfbt_pkg::first_set(empty), tag_width_sel, tag_m);
    end else begin
      wb_data = cfbt_pkg::put_slot(rd_data, item.victim_slot, tag_width_sel, tag_m);
    end
  end

  // Result fields by command
  always_comb begin
    result = '0;
    unique case (item.command)
      cfbt_pkg::CMD_LOOKUP2,
      cfbt_pkg::CMD_LOOKUP1,
      cfbt_pkg::CMD_DELETE:  result.success = hit;
      cfbt_pkg::CMD_INSERT: begin
        result.success = any_empty;
        result.evicted = do_evict;
        if (do_evict) begin
          result.evicted_tag = cfbt_pkg::get_slot(rd_data, item.victim_slot, tag_width_sel);
        end
      end
      cfbt_pkg::CMD_COUNT:   result.occupied_count = cfbt_pkg::COUNT_W'($countones(~empty));
      default:               result = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp <= result;
    end
  end

  assign status.clr_last      = (clr_addr == cfbt_pkg::BIDX_W'(cfbt_pkg::BUCKET_COUNT - 1));
  assign status.hit           = hit;
  assign status.any_empty     = any_empty;
  assign status.evict_on_full = item.evict_on_full;
  assign status.command       = item.command;

endmodule

>>> rtl/cfbt_ctrl.sv
// Controller: clearing sweep, read sequencing, write-back and result handshake.
`timescale 1ns / 1ps
`include "cuckoo_filter_bucket_table_unit_macros.svh"
module cfbt_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  input  cfbt_pkg::ctrl_status_t  status,
  output cfbt_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_ALT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   needs_wb;

  // Result register can take a new value when empty or being drained now
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  assign needs_wb = ((status.command == cfbt_pkg::CMD_DELETE) && status.hit) ||
                    ((status.command == cfbt_pkg::CMD_INSERT) &&
                     (status.any_empty || status.evict_on_full));

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          cmd.rd_en  = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          if ((status.command == cfbt_pkg::CMD_LOOKUP2) && !status.hit) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_alt = 1'b1;
            state_next = ST_ALT;
          end else begin
            cmd.wb_en    = needs_wb;
            cmd.out_load = 1'b1;
            state_next   = ST_IDLE;
          end
        end
      end
      ST_ALT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // A new result never overwrites one that is still waiting
  `CFBT_ASSERT(a_no_overwrite, clk, rst, cmd.out_load |-> !(rsp_valid && rsp_stall), "result overwritten while stalled")
  // An accepted transaction goes straight to evaluation
  `CFBT_ASSERT(a_accept_eval, clk, rst, (req_valid && !req_stall) |=> (state == ST_EVAL), "accept did not start evaluation")
  // Reset always starts the clearing sweep
  `CFBT_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (state == ST_CLEAR && !rsp_valid), "reset did not start clearing")
  // No memory write-back and no accepted request while the sweep is still running
  `CFBT_ASSERT(a_no_wb_clear, clk, rst, (state == ST_CLEAR) |-> !cmd.wb_en && !cmd.accept, "work during clearing")

endmodule

>>> rtl/cuckoo_filter_bucket_table_unit.sv
// Top level of the cuckoo filter bucket table: controller plus datapath.
//
//   Channel | Signals                      | Payload
//   --------+------------------------------+--------------------------
//   request | req_valid, req_stall         | req  (cfbt_pkg::req_t)
//   result  | rsp_valid, rsp_stall         | rsp  (cfbt_pkg::rsp_t)
//   config  | cfg_valid, cfg_ready         | cfg_data (tag width select)
//
// Each transaction does one registered bucket read, then compare, write-back
// and result load. A two-bucket lookup that misses the primary bucket then reads
// the alternate bucket as well, through the single memory read port.
// After reset a clearing sweep writes all 1024 buckets, one per cycle, and
// requests are stalled until it ends; configuration writes are always taken.
// A stalled result holds the block in evaluation; the next request can still
// be accepted while the previous result waits.
`timescale 1ns / 1ps
module cuckoo_filter_bucket_table_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  cfbt_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output cfbt_pkg::rsp_t              rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cfbt_pkg::SEL_W-1:0]  cfg_data
);

  cfbt_pkg::ctrl_cmd_t    cmd;
  cfbt_pkg::ctrl_status_t status;

  assign cfg_ready = 1'b1;

  cfbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cfbt_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .req      (req),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .rsp      (rsp)
  );

endmodule

>>> tb/sv/cfbt_checker.sv
// Checker for the cuckoo filter bucket table: tracks the table, predicts and compares results.
`timescale 1ns / 1ps
module cfbt_checker
  import cfbt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_stall,
  input  req_t             req,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  rsp_t             rsp,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [SEL_W-1:0] cfg_data,
  output int               errors,
  output int               outstanding
);

  // Shadow copy of the bucket memory and the width register
  logic [BUCKET_W-1:0] bucket_mem [BUCKET_COUNT];
  logic [SEL_W-1:0]    width_sel;
  rsp_t                awaited_results [$];
  int                  err_cnt;

  initial begin
    errors      = 0;
    outstanding = 0;
    err_cnt     = 0;
  end

  function automatic int tag_bits(logic [SEL_W-1:0] sel);
    case (sel)
      WSEL_2:  return 2;
      WSEL_4:  return 4;
      WSEL_8:  return 8;
      WSEL_12: return 12;
      WSEL_16: return 16;
      default: return 32; // 32 and the reserved codes
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] lane_mask(int w);
    logic [63:0] m;
    m = (64'd1 << w) - 64'd1;
    return m[TAG_W-1:0];
  endfunction

  // Slot s sits at bits [s*w, s*w+w) of the packed bucket
  function automatic logic [TAG_W-1:0] slot_read(logic [BUCKET_W-1:0] b, int s, int w);
    logic [BUCKET_W-1:0] t;
    t = b >> (s * w);
    return t[TAG_W-1:0] & lane_mask(w);
  endfunction

  function automatic logic [BUCKET_W-1:0] slot_write(logic [BUCKET_W-1:0] b, int s, int w,
                                                     logic [TAG_W-1:0] val);
    logic [BUCKET_W-1:0] m;
    logic [BUCKET_W-1:0] v;
    m = {{(BUCKET_W-TAG_W){1'b0}}, lane_mask(w)} << (s * w);
    v = {{(BUCKET_W-TAG_W){1'b0}}, val & lane_mask(w)} << (s * w);
    return (b & ~m) | v;
  endfunction

  function automatic int find_slot(logic [BUCKET_W-1:0] b, logic [TAG_W-1:0] tag, int w);
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (slot_read(b, s, w) == tag) return s;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and return the result it gives
  function automatic rsp_t apply_command(req_t r);
    rsp_t                res;
    int                  w;
    int                  hit;
    int                  n_used;
    logic [TAG_W-1:0]    tag;
    logic [BUCKET_W-1:0] pb;
    logic [BUCKET_W-1:0] ab;
    res    = '0;
    n_used = 0;
    w      = tag_bits(width_sel);
    tag    = r.tag_value & lane_mask(w);
    pb     = bucket_mem[r.bucket_index];
    ab     = bucket_mem[r.alt_bucket_index];
    case (r.command)
      CMD_LOOKUP2: begin
        res.success = (find_slot(pb, tag, w) >= 0) || (find_slot(ab, tag, w) >= 0);
      end
      CMD_LOOKUP1: begin
        res.success = find_slot(pb, tag, w) >= 0;
      end
      CMD_DELETE: begin
        hit = find_slot(pb, tag, w);
        if (hit >= 0) begin
          bucket_mem[r.bucket_index] = slot_write(pb, hit, w, '0);
          res.success = 1'b1;
        end
      end
      CMD_INSERT: begin
        hit = find_slot(pb, '0, w);
        if (hit >= 0) begin
          bucket_mem[r.bucket_index] = slot_write(pb, hit, w, tag);
          res.success = 1'b1;
        end else if (r.evict_on_full) begin
          res.evicted_tag = slot_read(pb, int'(r.victim_slot), w);
          bucket_mem[r.bucket_index] = slot_write(pb, int'(r.victim_slot), w, tag);
          res.evicted = 1'b1;
        end
      end
      CMD_COUNT: begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
          if (slot_read(pb, s, w) != '0) n_used++;
        end
        res.occupied_count = n_used[COUNT_W-1:0];
      end
      default: ; // unused commands touch nothing
    endcase
    return res;
  endfunction

  task automatic note_mismatch(string field, logic [TAG_W-1:0] exp_v, logic [TAG_W-1:0] got_v);
    err_cnt++;
    $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
  endtask

  // Watch all three channels; results are checked before a new request is queued
  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst) begin
      for (int i = 0; i < BUCKET_COUNT; i++) bucket_mem[i] = '0;
      width_sel = WSEL_RESET;
      awaited_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          err_cnt++;
          $display("%0t ns: result with none expected, got 0x%0h", $time, rsp);
        end else begin
          exp_r = awaited_results.pop_front();
          if (rsp.success != exp_r.success)
            note_mismatch("success", exp_r.success, rsp.success);
          if (rsp.evicted != exp_r.evicted)
            note_mismatch("evicted", exp_r.evicted, rsp.evicted);
          if (rsp.evicted_tag !== exp_r.evicted_tag)
            note_mismatch("evicted_tag", exp_r.evicted_tag, rsp.evicted_tag);
          if (rsp.occupied_count !== exp_r.occupied_count)
            note_mismatch("occupied_count", exp_r.occupied_count, rsp.occupied_count);
        end
      end
      if (cfg_valid && cfg_ready) width_sel = cfg_data;
      if (req_valid && !req_stall) awaited_results.push_back(apply_command(req));
    end
    errors      <= err_cnt;
    outstanding <= awaited_results.size();
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the cuckoo filter bucket table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import cfbt_pkg::*;

  // Command and width codes with no name in the package
  localparam logic [CMD_W-1:0] CMD_RSVD5  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7  = 3'd7;
  localparam logic [SEL_W-1:0] WSEL_RSVD6 = 3'd6;
  localparam logic [SEL_W-1:0] WSEL_RSVD7 = 3'd7;

  localparam int PHASE_ITEMS = 119;
  localparam int NUM_PHASES  = 8;
  localparam int HOT_BUCKETS = 8;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [SEL_W-1:0] cfg_data;
  int               errors;
  int               outstanding;
  logic             calm;

  logic [BIDX_W-1:0] hot_bucket [HOT_BUCKETS];
  logic [TAG_W-1:0]  recent_tags [$];
  logic [SEL_W-1:0]  phase_width [NUM_PHASES];

  cuckoo_filter_bucket_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  cfbt_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #2_000_000;
    $display("** cuckoo_filter_bucket_table_unit: FAILED **");
    $finish;
  end

  // Result side back-pressure
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_stall <= !calm && ($urandom_range(0, 99) < 36);
    end
  end

  function automatic req_t make_req(logic [CMD_W-1:0] cmd, logic [BIDX_W-1:0] b,
                                    logic [BIDX_W-1:0] a, logic [TAG_W-1:0] tag,
                                    logic ev, logic [SLOT_IDX_W-1:0] vs);
    req_t r;
    r.command          = cmd;
    r.bucket_index     = b;
    r.alt_bucket_index = a;
    r.tag_value        = tag;
    r.evict_on_full    = ev;
    r.victim_slot      = vs;
    return r;
  endfunction

  // Mostly traffic on a few hot buckets, often with tags that were inserted before
  function automatic req_t random_op();
    req_t              r;
    int                pick;
    logic [CMD_W-1:0]  cmd;
    logic [BIDX_W-1:0] b;
    logic [BIDX_W-1:0] a;
    logic [TAG_W-1:0]  tag;
    pick = $urandom_range(0, 99);
    if (pick < 30)      cmd = CMD_INSERT;
    else if (pick < 45) cmd = CMD_DELETE;
    else if (pick < 62) cmd = CMD_LOOKUP2;
    else if (pick < 77) cmd = CMD_LOOKUP1;
    else if (pick < 92) cmd = CMD_COUNT;
    else begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_RSVD5;
        1:       cmd = CMD_RSVD6;
        default: cmd = CMD_RSVD7;
      endcase
    end
    b = ($urandom_range(0, 99) < 80) ? hot_bucket[$urandom_range(0, HOT_BUCKETS - 1)]
                                     : BIDX_W'($urandom);
    a = ($urandom_range(0, 99) < 80) ? hot_bucket[$urandom_range(0, HOT_BUCKETS - 1)]
                                     : BIDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45 && recent_tags.size() > 0)
      tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
    else if (pick < 55)
      tag = '0;
    else
      tag = $urandom;
    if (cmd == CMD_INSERT) begin
      recent_tags.push_back(tag);
      if (recent_tags.size() > 16) void'(recent_tags.pop_front());
    end
    r = make_req(cmd, b, a, tag, 1'($urandom), SLOT_IDX_W'($urandom));
    return r;
  endfunction

  // One request transaction, with random idle cycles ahead of it
  task automatic send_req(req_t r);
    while (!calm && ($urandom_range(0, 99) < 36)) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
  endtask

  // Width change, only once all results are back and the block has settled
  task automatic set_width(logic [SEL_W-1:0] sel);
    req_valid <= 1'b0;
    // let the count of awaited results take in the last accepted request
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    localparam logic [BIDX_W-1:0] BTOP = '1;
    localparam logic [BIDX_W-1:0] BLOW = '0;
    req_t d [$];
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= WSEL_RESET;
    calm      <= 1'b0;
    phase_width = '{WSEL_2, WSEL_32, WSEL_12, WSEL_RSVD6, WSEL_4, WSEL_16, WSEL_RSVD7, WSEL_8};
    hot_bucket[0] = BLOW;
    hot_bucket[1] = BTOP;
    for (int i = 2; i < HOT_BUCKETS; i++) hot_bucket[i] = BIDX_W'($urandom);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset width of 8 bits, top bucket filled then evicted
    d.push_back(make_req(CMD_COUNT,   BTOP, BLOW, 32'h0,         1'b0, 2'd0));
    d.push_back(make_req(CMD_LOOKUP1, BTOP, BLOW, 32'hFFFF_FF00, 1'b0, 2'd0));
    d.push_back(make_req(CMD_INSERT,  BTOP, BLOW, 32'h0000_00FF, 1'b0, 2'd0));
    d.push_back(make_req(CMD_INSERT,  BTOP, BLOW, 32'h1234_5601, 1'b0, 2'd0));
    d.push_back(make_req(CMD_INSERT,  BTOP, BLOW, 32'hFFFF_FF80, 1'b0, 2'd0));
    d.push_back(make_req(CMD_INSERT,  BTOP, BLOW, 32'hFFFF_FF00, 1'b0, 2'd0));
    d.push_back(make_req(CMD_INSERT,  BTOP, BLOW, 32'h0000_0042, 1'b0, 2'd0));
    d.push_back(make_req(CMD_INSERT,  BTOP, BLOW, 32'h0000_0007, 1'b0, 2'd3));
    d.push_back(make_req(CMD_INSERT,  BTOP, BLOW, 32'hAAAA_AA33, 1'b1, 2'd3));
    d.push_back(make_req(CMD_COUNT,   BTOP, BLOW, 32'hFFFF_FFFF, 1'b1, 2'd3));
    d.push_back(make_req(CMD_LOOKUP1, BTOP, BLOW, 32'h0,         1'b0, 2'd0));
    d.push_back(make_req(CMD_LOOKUP2, BLOW, BTOP, 32'h0000_0080, 1'b0, 2'd0));
    d.push_back(make_req(CMD_LOOKUP2, BTOP, 10'd512, 32'h0000_0099, 1'b0, 2'd0));
    d.push_back(make_req(CMD_LOOKUP2, BTOP, BLOW, 32'h0000_0001, 1'b0, 2'd0));
    d.push_back(make_req(CMD_DELETE,  BTOP, BLOW, 32'h5555_5501, 1'b0, 2'd0));
    d.push_back(make_req(CMD_DELETE,  BTOP, BLOW, 32'h0000_0001, 1'b0, 2'd0));
    d.push_back(make_req(CMD_DELETE,  BTOP, BLOW, 32'h0000_0000, 1'b0, 2'd0));
    d.push_back(make_req(CMD_INSERT,  BTOP, BLOW, 32'h0000_0055, 1'b1, 2'd1));
    d.push_back(make_req(CMD_RSVD5,   BTOP, BTOP, 32'hFFFF_FFFF, 1'b1, 2'd3));
    d.push_back(make_req(CMD_RSVD6,   BTOP, BTOP, 32'hFFFF_FFFF, 1'b1, 2'd3));
    d.push_back(make_req(CMD_RSVD7,   BTOP, BTOP, 32'hFFFF_FFFF, 1'b1, 2'd3));
    d.push_back(make_req(CMD_COUNT,   BLOW, BLOW, 32'h0,         1'b0, 2'd0));
    d.push_back(make_req(CMD_INSERT,  BLOW, BLOW, 32'h0000_0011, 1'b1, 2'd2));
    d.push_back(make_req(CMD_LOOKUP1, BLOW, BTOP, 32'hFFFF_FF11, 1'b0, 2'd0));
    foreach (d[i]) send_req(d[i]);

    // Random phases, one tag width each; table contents carry across width changes
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_width(phase_width[p]);
      calm <= (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_req(random_op());
    end
    req_valid <= 1'b0;
    calm      <= 1'b0;

    @(posedge clk);
    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("** cuckoo_filter_bucket_table_unit: PASSED **");
    end else begin
      $display("** cuckoo_filter_bucket_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
